FILE: rtl/tpcm_pkg.sv
package tpcm_pkg;

    localparam int NUM_CHANNELS_DEF = 18;
    localparam int PADDR_W          = 3;
    localparam int HORNER_TERMS     = 9;
    localparam int HORNER_STEPS     = HORNER_TERMS - 1;
    localparam int TBL_CNT          = 4;

    localparam logic [10:0] NEUTRAL_US = 11'd1500;
    localparam logic [10:0] LIM_LO_STD = 11'd1100;
    localparam logic [10:0] LIM_HI_STD = 11'd1900;
    localparam logic [10:0] LIM_LO_WIDE = 11'd1000;
    localparam logic [10:0] LIM_HI_WIDE = 11'd2000;

    // pwm model codes
    localparam logic [1:0] MODEL_POLY_A = 2'd0;
    localparam logic [1:0] MODEL_POLY_B = 2'd1;
    localparam logic [1:0] MODEL_LINEAR = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_PWM_MODEL   = 1'b0;
    localparam logic REG_LINEAR_GAIN = 1'b1;

    localparam logic [1:0]  MODEL_RESET = MODEL_POLY_A;
    localparam logic [15:0] GAIN_RESET  = 16'd5120;

    // dead band edges on the Q16.16 grid
    localparam logic signed [31:0] DB_A_REV = -32'sd23783;
    localparam logic signed [31:0] DB_A_FWD = 32'sd26752;
    localparam logic signed [31:0] DB_B_REV = -32'sd19660;
    localparam logic signed [31:0] DB_B_FWD = 32'sd19660;

    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        TBL_A_REV = 2'd0,
        TBL_A_FWD = 2'd1,
        TBL_B_REV = 2'd2,
        TBL_B_FWD = 2'd3
    } tbl_sel_t;

    typedef struct packed {
        logic signed [31:0] thrust;
        logic               command_valid;
        logic signed [15:0] channel_scale;
        logic [4:0]         channel_number;
    } tpcm_in_t;

    typedef struct packed {
        logic [4:0]  out_channel;
        logic [10:0] pulse_width;
        logic        write_enable;
    } tpcm_out_t;

    typedef struct packed {
        logic [1:0]         pwm_model;
        logic signed [15:0] linear_gain;
    } tpcm_cfg_t;

    // per-request control that rides along the pipeline
    typedef struct packed {
        logic               wr_en;
        logic               lim_wide;
        logic               direct;
        tbl_sel_t           tbl_sel;
        logic               x_neg;
        logic [31:0]        x_mag;
        logic [4:0]         channel;
        logic signed [15:0] scale;
        logic [10:0]        raw_direct;
    } tpcm_side_t;

    typedef logic [TBL_CNT-1:0][63:0] coef_set_t;

    // decimal coefficient to signed Q15.48, rounded half away from zero
    function automatic logic signed [63:0] coef_q48(input longint mant, input int exp10);
        logic [63:0]  den;
        logic [63:0]  mag;
        logic [127:0] num;
        logic [127:0] rem;
        logic [127:0] quo;
        int           k;
        int           i;
        den = 64'd1;
        k   = 8 - exp10;
        for (i = 0; i < k; i++) begin
            den = den * 64'd10;
        end
        mag = (mant < 0) ? 64'(-mant) : 64'(mant);
        num = 128'(mag) << 48;
        rem = '0;
        quo = '0;
        for (i = 127; i >= 0; i--) begin
            rem = {rem[126:0], num[i]};
            if (rem >= 128'(den)) begin
                rem    = rem - 128'(den);
                quo[i] = 1'b1;
            end
        end
        if ((rem << 1) >= 128'(den)) begin
            quo = quo + 128'd1;
        end
        return (mant < 0) ? -$signed(quo[63:0]) : $signed(quo[63:0]);
    endfunction

    // first term is the leading coefficient; degree-6 tables lead with two zeros
    localparam logic signed [63:0] COEF_TAB [TBL_CNT][HORNER_TERMS] = '{
        '{coef_q48(419120215, -9), coef_q48(725765393, -7), coef_q48(512089798, -5),
          coef_q48(189821056, -3), coef_q48(397888906, -2), coef_q48(476560866, -1),
          coef_q48(331574457, 0),  coef_q48(241195184, 1),  coef_q48(147508532, 3)},
        '{coef_q48(-389443834, -10), coef_q48(897208792, -8), coef_q48(842626420, -6),
          coef_q48(416470611, -4),   coef_q48(116830379, -2), coef_q48(188609133, -1),
          coef_q48(179496731, 0),    coef_q48(183042688, 1),  coef_q48(152666998, 3)},
        '{64'sd0, 64'sd0,
          coef_q48(378328199, -8), coef_q48(124896612, -5), coef_q48(124135724, -3),
          coef_q48(529618237, -2), coef_q48(105292003, 0),  coef_q48(169210385, 1),
          coef_q48(148493125, 3)},
        '{64'sd0, 64'sd0,
          coef_q48(307095665, -8),  coef_q48(-655375382, -6), coef_q48(530480570, -4),
          coef_q48(-194854716, -2), coef_q48(280240130, -1),  coef_q48(506028546, 0),
          coef_q48(152849853, 3)}
    };

    function automatic coef_set_t coef_column(input int k);
        coef_set_t c;
        int        t;
        for (t = 0; t < TBL_CNT; t++) begin
            c[t] = COEF_TAB[t][k];
        end
        return c;
    endfunction

    // clamp a value with fb fraction bits to the model limits, round half away
    function automatic logic [10:0] clamp_round(input logic signed [64:0] v, input int fb,
                                                input logic wide);
        logic [10:0]        lo;
        logic [10:0]        hi;
        logic signed [64:0] lo_v;
        logic signed [64:0] hi_v;
        logic signed [64:0] half;
        logic signed [64:0] r;
        lo   = wide ? LIM_LO_WIDE : LIM_LO_STD;
        hi   = wide ? LIM_HI_WIDE : LIM_HI_STD;
        lo_v = 65'(lo) << fb;
        hi_v = 65'(hi) << fb;
        half = 65'(1) << (fb - 1);
        r    = (v + half) >>> fb;
        if (v <= lo_v) begin
            return lo;
        end else if (v >= hi_v) begin
            return hi;
        end
        return r[10:0];
    endfunction

endpackage

FILE: rtl/thrust_to_pwm_channel_map.sv
// Thruster command to RC pulse width. Each request carries a Q16.16 thrust, a
// presence flag, a Q4.12 channel scale and a channel number; each gives exactly
// one result with the channel echoed, the pulse width in microseconds and a
// write enable (low, with width 0, for a missing command or a channel outside
// 1..NUM_CHANNELS). The width comes from the model selected by register 0
// (degree-8 or degree-6 two-sided polynomial with dead band, or 1500 plus the
// Q8.8 gain of register 1 times thrust), is clamped and rounded, then scaled
// about 1500 and clamped and rounded again. The block takes one request per
// clock unless the output stalls; each runs through decode and linear-model
// registers, eight Horner steps of four stages each (magnitude, split 32x32
// multiply, round and saturate, coefficient add) and the clamp and scaling
// registers. A one-entry input buffer keeps s_ready independent of m_ready.
// Registers are to be written only while no request is in flight.
module thrust_to_pwm_channel_map import tpcm_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tpcm_in_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tpcm_out_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    tpcm_cfg_t  cfg;
    logic       en;
    logic       skid_valid_reg;
    logic       skid_valid_next;
    tpcm_in_t   skid_data_reg;
    logic       entry_valid;
    tpcm_in_t   entry_data;

    logic               step_valid [HORNER_STEPS+1];
    tpcm_side_t         step_side  [HORNER_STEPS+1];
    logic signed [63:0] step_acc   [HORNER_STEPS+1];

    tpcm_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // whole pipeline advances while the output register is empty or being drained
    assign en      = !m_valid || m_ready;
    assign s_ready = !skid_valid_reg;

    assign entry_valid = skid_valid_reg || (s_valid && s_ready);
    assign entry_data  = skid_valid_reg ? skid_data_reg : s_data;

    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (en) begin
            skid_valid_next = 1'b0;
        end else if (s_valid && s_ready) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_valid && s_ready) begin
            skid_data_reg <= s_data;
        end
    end

    tpcm_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (entry_valid),
        .in_data   (entry_data),
        .cfg       (cfg),
        .out_valid (step_valid[0]),
        .out_side  (step_side[0]),
        .out_acc   (step_acc[0])
    );

    for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
        tpcm_horner_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (step_valid[k]),
            .in_side   (step_side[k]),
            .in_acc    (step_acc[k]),
            .coefs     (coef_column(k + 1)),
            .out_valid (step_valid[k+1]),
            .out_side  (step_side[k+1]),
            .out_acc   (step_acc[k+1])
        );
    end

    tpcm_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (step_valid[HORNER_STEPS]),
        .in_side   (step_side[HORNER_STEPS]),
        .in_acc    (step_acc[HORNER_STEPS]),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_skid_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid && !m_ready))
        else $error("input buffer filled while pipeline was moving");

    a_width_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.write_enable |->
            (m_data.pulse_width >= LIM_LO_WIDE) && (m_data.pulse_width <= LIM_HI_WIDE))
        else $error("pulse width outside limits");

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.write_enable |-> m_data.pulse_width == 11'd0)
        else $error("nonzero width on a disabled write");

endmodule

FILE: rtl/tpcm_apb_regs.sv
module tpcm_apb_regs import tpcm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tpcm_cfg_t          cfg
);

    logic [1:0]  model_reg;
    logic [1:0]  model_next;
    logic [15:0] gain_reg;
    logic [15:0] gain_next;
    logic        wr_stb;
    logic        reg_idx;

    assign pready  = 1'b1;
    assign wr_stb  = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1];

    always_comb begin
        model_next = model_reg;
        gain_next  = gain_reg;
        if (wr_stb) begin
            case (reg_idx)
                REG_PWM_MODEL:   model_next = pwdata[1:0];
                REG_LINEAR_GAIN: gain_next  = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_reg <= MODEL_RESET;
            gain_reg  <= GAIN_RESET;
        end else begin
            model_reg <= model_next;
            gain_reg  <= gain_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PWM_MODEL:   prdata = {30'd0, model_reg};
            REG_LINEAR_GAIN: prdata = {16'd0, gain_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.pwm_model   = model_reg;
    assign cfg.linear_gain = $signed(gain_reg);

endmodule

FILE: rtl/tpcm_front.sv
module tpcm_front import tpcm_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  tpcm_in_t           in_data,
    input  tpcm_cfg_t          cfg,
    output logic               out_valid,
    output tpcm_side_t         out_side,
    output logic signed [63:0] out_acc
);

    localparam coef_set_t COEF_HEAD = coef_column(0);

    logic               dec_valid_reg;
    tpcm_side_t         dec_side_reg;
    tpcm_side_t         dec_side_next;
    logic               dec_lin_reg;
    logic               dec_lin_next;
    logic signed [47:0] dec_prod_reg;
    logic signed [47:0] dec_prod_next;
    logic signed [63:0] dec_acc_reg;
    logic signed [63:0] dec_acc_next;

    logic               lin_valid_reg;
    tpcm_side_t         lin_side_reg;
    tpcm_side_t         lin_side_next;
    logic signed [63:0] lin_acc_reg;
    logic signed [64:0] lin_v;
    logic signed [31:0] x;

    assign x = in_data.thrust;

    always_comb begin
        dec_side_next.channel    = in_data.channel_number;
        dec_side_next.scale      = in_data.channel_scale;
        dec_side_next.wr_en      = in_data.command_valid && (in_data.channel_number != 5'd0)
                                   && (in_data.channel_number <= 5'(NUM_CHANNELS));
        dec_side_next.x_neg      = x[31];
        dec_side_next.x_mag      = x[31] ? (~x + 32'd1) : x;
        dec_side_next.lim_wide   = (cfg.pwm_model == MODEL_POLY_B);
        dec_side_next.direct     = 1'b1;
        dec_side_next.tbl_sel    = TBL_A_REV;
        dec_side_next.raw_direct = NEUTRAL_US;
        dec_lin_next             = 1'b0;
        case (cfg.pwm_model)
            MODEL_POLY_A: begin
                if (x < DB_A_REV) begin
                    dec_side_next.direct  = 1'b0;
                    dec_side_next.tbl_sel = TBL_A_REV;
                end else if (x >= DB_A_FWD) begin
                    dec_side_next.direct  = 1'b0;
                    dec_side_next.tbl_sel = TBL_A_FWD;
                end
            end
            MODEL_POLY_B: begin
                if (x < DB_B_REV) begin
                    dec_side_next.direct  = 1'b0;
                    dec_side_next.tbl_sel = TBL_B_REV;
                end else if (x > DB_B_FWD) begin
                    dec_side_next.direct  = 1'b0;
                    dec_side_next.tbl_sel = TBL_B_FWD;
                end
            end
            default: dec_lin_next = 1'b1;
        endcase
        dec_prod_next = cfg.linear_gain * x;
        dec_acc_next  = $signed(COEF_HEAD[dec_side_next.tbl_sel]);
    end

    // linear model: Q24.24 value 1500 + gain*thrust
    assign lin_v = {{17{dec_prod_reg[47]}}, dec_prod_reg} + (65'(NEUTRAL_US) << 24);

    always_comb begin
        lin_side_next = dec_side_reg;
        if (dec_lin_reg) begin
            lin_side_next.raw_direct = clamp_round(lin_v, 24, 1'b0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
            lin_valid_reg <= 1'b0;
        end else if (en) begin
            dec_valid_reg <= in_valid;
            lin_valid_reg <= dec_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dec_side_reg <= dec_side_next;
            dec_lin_reg  <= dec_lin_next;
            dec_prod_reg <= dec_prod_next;
            dec_acc_reg  <= dec_acc_next;
            lin_side_reg <= lin_side_next;
            lin_acc_reg  <= dec_acc_reg;
        end
    end

    assign out_valid = lin_valid_reg;
    assign out_side  = lin_side_reg;
    assign out_acc   = lin_acc_reg;

endmodule

FILE: rtl/tpcm_horner_step.sv
module tpcm_horner_step import tpcm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  tpcm_side_t         in_side,
    input  logic signed [63:0] in_acc,
    input  coef_set_t          coefs,
    output logic               out_valid,
    output tpcm_side_t         out_side,
    output logic signed [63:0] out_acc
);

    // magnitude stage
    logic        nrm_valid_reg;
    tpcm_side_t  nrm_side_reg;
    logic [63:0] nrm_mag_reg;
    logic [63:0] nrm_mag_next;
    logic        nrm_neg_reg;
    logic        nrm_neg_next;

    // partial products
    logic        mul_valid_reg;
    tpcm_side_t  mul_side_reg;
    logic [63:0] mul_phi_reg;
    logic [63:0] mul_phi_next;
    logic [63:0] mul_plo_reg;
    logic [63:0] mul_plo_next;
    logic        mul_neg_reg;

    // rounded, saturated product magnitude
    logic        cmb_valid_reg;
    tpcm_side_t  cmb_side_reg;
    logic [63:0] cmb_mag_reg;
    logic [63:0] cmb_mag_next;
    logic [63:0] cmb_low;
    logic [63:0] cmb_sum;
    logic        cmb_neg_reg;

    // coefficient add
    logic               add_valid_reg;
    tpcm_side_t         add_side_reg;
    logic signed [63:0] add_acc_reg;
    logic signed [63:0] add_acc_next;
    logic [63:0]        add_coef;
    logic [64:0]        add_sum;

    always_comb begin
        nrm_mag_next = in_acc[63] ? (~in_acc + 64'd1) : in_acc;
        nrm_neg_next = in_acc[63] ^ in_side.x_neg;
    end

    always_comb begin
        mul_phi_next = nrm_mag_reg[63:32] * nrm_side_reg.x_mag;
        mul_plo_next = nrm_mag_reg[31:0] * nrm_side_reg.x_mag;
    end

    always_comb begin
        cmb_low = {16'd0, mul_plo_reg[63:16]} + {63'd0, mul_plo_reg[15]};
        cmb_sum = {mul_phi_reg[47:0], 16'd0} + cmb_low;
        if ((mul_phi_reg[63:47] != 17'd0) || cmb_sum[63]) begin
            cmb_mag_next = SAT_MAX;
        end else begin
            cmb_mag_next = cmb_sum;
        end
    end

    // signed product plus coefficient, one adder; overflow shows in the top two bits
    always_comb begin
        add_coef = coefs[cmb_side_reg.tbl_sel];
        if (cmb_neg_reg) begin
            add_sum = {add_coef[63], add_coef} - {1'b0, cmb_mag_reg};
        end else begin
            add_sum = {add_coef[63], add_coef} + {1'b0, cmb_mag_reg};
        end
        if (add_sum[64] != add_sum[63]) begin
            add_acc_next = add_sum[64] ? $signed(SAT_MIN) : $signed(SAT_MAX);
        end else begin
            add_acc_next = $signed(add_sum[63:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nrm_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            cmb_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
        end else if (en) begin
            nrm_valid_reg <= in_valid;
            mul_valid_reg <= nrm_valid_reg;
            cmb_valid_reg <= mul_valid_reg;
            add_valid_reg <= cmb_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nrm_side_reg <= in_side;
            nrm_mag_reg  <= nrm_mag_next;
            nrm_neg_reg  <= nrm_neg_next;
            mul_side_reg <= nrm_side_reg;
            mul_phi_reg  <= mul_phi_next;
            mul_plo_reg  <= mul_plo_next;
            mul_neg_reg  <= nrm_neg_reg;
            cmb_side_reg <= mul_side_reg;
            cmb_mag_reg  <= cmb_mag_next;
            cmb_neg_reg  <= mul_neg_reg;
            add_side_reg <= cmb_side_reg;
            add_acc_reg  <= add_acc_next;
        end
    end

    assign out_valid = add_valid_reg;
    assign out_side  = add_side_reg;
    assign out_acc   = add_acc_reg;

endmodule

FILE: rtl/tpcm_finish.sv
module tpcm_finish import tpcm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  tpcm_side_t         in_side,
    input  logic signed [63:0] in_acc,
    output logic               out_valid,
    output tpcm_out_t          out_data
);

    logic               raw_valid_reg;
    tpcm_side_t         raw_side_reg;
    logic [10:0]        raw_reg;
    logic [10:0]        raw_next;

    logic               scl_valid_reg;
    tpcm_side_t         scl_side_reg;
    logic signed [27:0] scl_prod_reg;
    logic signed [27:0] scl_prod_next;
    logic signed [11:0] scl_diff;

    logic               out_valid_reg;
    tpcm_out_t          out_reg;
    tpcm_out_t          out_next;
    logic signed [64:0] out_v;
    logic [10:0]        out_pw;

    always_comb begin
        if (in_side.direct) begin
            raw_next = in_side.raw_direct;
        end else begin
            raw_next = clamp_round({in_acc[63], in_acc}, 48, in_side.lim_wide);
        end
    end

    always_comb begin
        scl_diff      = $signed({1'b0, raw_reg}) - $signed({1'b0, NEUTRAL_US});
        scl_prod_next = raw_side_reg.scale * scl_diff;
    end

    // Q.12 value 1500 + scale*(raw-1500)
    always_comb begin
        out_v                 = {{37{scl_prod_reg[27]}}, scl_prod_reg} + (65'(NEUTRAL_US) << 12);
        out_pw                = clamp_round(out_v, 12, scl_side_reg.lim_wide);
        out_next.out_channel  = scl_side_reg.channel;
        out_next.write_enable = scl_side_reg.wr_en;
        out_next.pulse_width  = scl_side_reg.wr_en ? out_pw : 11'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_valid_reg <= 1'b0;
            scl_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            raw_valid_reg <= in_valid;
            scl_valid_reg <= raw_valid_reg;
            out_valid_reg <= scl_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            raw_side_reg <= in_side;
            raw_reg      <= raw_next;
            scl_side_reg <= raw_side_reg;
            scl_prod_reg <= scl_prod_next;
            out_reg      <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: bench/pwm_result_checker.sv
`timescale 1ns / 1ps

module pwm_result_checker import tpcm_pkg::*; #(
    parameter int NUM_CH = NUM_CHANNELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  tpcm_in_t           s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  tpcm_out_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending
);

    localparam longint NEUTRAL  = 1500;
    localparam longint STD_LO   = 1100;
    localparam longint STD_HI   = 1900;
    localparam longint WIDE_LO  = 1000;
    localparam longint WIDE_HI  = 2000;
    // dead band edges on the Q16.16 grid
    localparam longint BAND_A_REV = -23783;
    localparam longint BAND_A_FWD = 26752;
    localparam longint BAND_B     = 19660;
    localparam longint ACC_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN    = 64'sh8000_0000_0000_0000;

    // decimal coefficients, leading term first: value = mant * 10^(exp - 8)
    localparam int COEF_MANT [4][9] = '{
        '{419120215, 725765393, 512089798, 189821056, 397888906, 476560866,
          331574457, 241195184, 147508532},
        '{-389443834, 897208792, 842626420, 416470611, 116830379, 188609133,
          179496731, 183042688, 152666998},
        '{378328199, 124896612, 124135724, 529618237, 105292003, 169210385,
          148493125, 0, 0},
        '{307095665, -655375382, 530480570, -194854716, 280240130, 506028546,
          152849853, 0, 0}
    };
    localparam int COEF_EXP [4][9] = '{
        '{-9, -7, -5, -3, -2, -1, 0, 1, 3},
        '{-10, -8, -6, -4, -2, -1, 0, 1, 3},
        '{-8, -5, -3, -2, 0, 1, 3, 0, 0},
        '{-8, -6, -4, -2, -1, 0, 3, 0, 0}
    };
    localparam int COEF_TERMS [4] = '{9, 9, 7, 7};

    tpcm_out_t   expected_pulses [$];
    logic [1:0]  cfg_model = MODEL_POLY_A;
    logic [15:0] cfg_gain  = 16'd5120;
    int          mismatch_count = 0;

    assign errors = mismatch_count;

    // decimal to Q48 by long division, rounded half away from zero
    function automatic longint coef_fixed(int mant, int exp10);
        longint unsigned den;
        longint unsigned m;
        longint unsigned q;
        longint unsigned r;
        int              i;
        den = 1;
        for (i = 0; i < 8 - exp10; i++) begin
            den = den * 10;
        end
        m = longint'(mant);
        if (mant < 0) begin
            m = 0 - m;
        end
        q = m / den;
        r = m % den;
        for (i = 0; i < 48; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        if (r * 2 >= den) begin
            q = q + 1;
        end
        return (mant < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Q48 times Q16.16, magnitude rounded half up, saturating
    function automatic longint q48_mul(longint v, longint x);
        longint unsigned a;
        longint unsigned b;
        longint unsigned phi;
        longint unsigned plo;
        longint unsigned lowp;
        longint unsigned mag;
        longint unsigned lim;
        bit              neg;
        a = v;
        if (v < 0) begin
            a = 0 - a;
        end
        b = x;
        if (x < 0) begin
            b = 0 - b;
        end
        lim = ACC_MAX;
        neg = (v < 0) != (x < 0);
        phi = (a >> 32) * b;
        plo = (a & 64'hFFFF_FFFF) * b;
        if (phi >= (64'd1 << 47)) begin
            mag = lim;
        end else begin
            lowp = (plo >> 16) + ((plo >> 15) & 64'd1);
            mag  = phi << 16;
            mag  = (lowp > lim - mag) ? lim : mag + lowp;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint q48_add(longint a, longint c);
        if (c > 0 && a > ACC_MAX - c) begin
            return ACC_MAX;
        end
        if (c < 0 && a < ACC_MIN - c) begin
            return ACC_MIN;
        end
        return a + c;
    endfunction

    function automatic longint horner_q48(int t, longint x);
        longint acc;
        int     i;
        acc = coef_fixed(COEF_MANT[t][0], COEF_EXP[t][0]);
        for (i = 1; i < COEF_TERMS[t]; i++) begin
            acc = q48_add(q48_mul(acc, x), coef_fixed(COEF_MANT[t][i], COEF_EXP[t][i]));
        end
        return acc;
    endfunction

    function automatic longint width_clamp(longint v, int fb, longint lo, longint hi);
        longint one;
        one = longint'(1) << fb;
        if (v <= lo * one) begin
            return lo;
        end
        if (v >= hi * one) begin
            return hi;
        end
        return (v + (one >>> 1)) >>> fb;
    endfunction

    function automatic tpcm_out_t predict_pulse(tpcm_in_t cmd, logic [1:0] model,
                                                logic [15:0] gain);
        tpcm_out_t res;
        longint    x;
        longint    v;
        longint    raw;
        longint    lo;
        longint    hi;
        longint    g;
        longint    sc;
        res.out_channel  = cmd.channel_number;
        res.pulse_width  = '0;
        res.write_enable = 1'b0;
        if (!cmd.command_valid || cmd.channel_number == 0 || cmd.channel_number > NUM_CH) begin
            return res;
        end
        x  = $signed(cmd.thrust);
        sc = $signed(cmd.channel_scale);
        g  = $signed(gain);
        lo = (model == MODEL_POLY_B) ? WIDE_LO : STD_LO;
        hi = (model == MODEL_POLY_B) ? WIDE_HI : STD_HI;
        case (model)
            MODEL_POLY_A: begin
                if (x < BAND_A_REV) begin
                    v = horner_q48(int'(TBL_A_REV), x);
                end else if (x >= BAND_A_FWD) begin
                    v = horner_q48(int'(TBL_A_FWD), x);
                end else begin
                    v = NEUTRAL << 48;
                end
                raw = width_clamp(v, 48, lo, hi);
            end
            MODEL_POLY_B: begin
                if (x < -BAND_B) begin
                    v = horner_q48(int'(TBL_B_REV), x);
                end else if (x > BAND_B) begin
                    v = horner_q48(int'(TBL_B_FWD), x);
                end else begin
                    v = NEUTRAL << 48;
                end
                raw = width_clamp(v, 48, lo, hi);
            end
            // the spare code falls through to the linear gain
            default: begin
                v   = (NEUTRAL << 24) + g * x;
                raw = width_clamp(v, 24, lo, hi);
            end
        endcase
        v = (NEUTRAL << 12) + sc * (raw - NEUTRAL);
        res.pulse_width  = 11'(width_clamp(v, 12, lo, hi));
        res.write_enable = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : watch
        tpcm_out_t want;
        if (!aresetn) begin
            cfg_model = MODEL_POLY_A;
            cfg_gain  = 16'd5120;
        end else begin
            if (s_valid && s_ready) begin
                expected_pulses = {expected_pulses,
                                   predict_pulse(s_data, cfg_model, cfg_gain)};
            end
            if (m_valid && m_ready) begin
                if (expected_pulses.size() == 0) begin
                    report_mismatch("result with no request pending", m_data, 0);
                end else begin
                    want = expected_pulses.pop_front();
                    if (m_data.out_channel != want.out_channel) begin
                        report_mismatch("out_channel", m_data.out_channel, want.out_channel);
                    end
                    if (m_data.pulse_width != want.pulse_width) begin
                        report_mismatch("pulse_width", m_data.pulse_width, want.pulse_width);
                    end
                    if (m_data.write_enable != want.write_enable) begin
                        report_mismatch("write_enable", m_data.write_enable,
                                        want.write_enable);
                    end
                end
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_PWM_MODEL) begin
                        cfg_model = pwdata[1:0];
                    end else begin
                        cfg_gain = pwdata[15:0];
                    end
                end else if (paddr[2] == REG_PWM_MODEL) begin
                    if (prdata[1:0] != cfg_model) begin
                        report_mismatch("pwm_model readback", prdata[1:0], cfg_model);
                    end
                end else if (prdata[15:0] != cfg_gain) begin
                    report_mismatch("linear_gain readback", prdata[15:0], cfg_gain);
                end
            end
        end
        pending <= expected_pulses.size();
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import tpcm_pkg::*;

    localparam int NUM_CH      = 18;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 110;
    localparam int SWAP_AT     = 370;
    localparam int CALM_AT     = 740;
    localparam int TAIL_CYCLES = 60;

    localparam logic [PADDR_W-1:0] ADDR_MODEL = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_GAIN  = 3'd4;
    localparam logic [1:0]         MODEL_SPARE = 2'd3;

    localparam int THRUST_MAX = 32'sh7FFF_FFFF;
    localparam int THRUST_MIN = 32'sh8000_0000;
    localparam int UNITY      = 4096;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    tpcm_in_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    tpcm_out_t          m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    int errors;
    int pending;
    int send_idle  = 17;
    int ready_idle = 81;
    int sent       = 0;

    thrust_to_pwm_channel_map #(.NUM_CHANNELS(NUM_CH)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pwm_result_checker #(.NUM_CH(NUM_CH)) i_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .errors  (errors),
        .pending (pending)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= ready_idle);
    end

    function automatic tpcm_in_t make_cmd(int thrust, bit valid, int scale, int ch);
        tpcm_in_t c;
        c.thrust         = thrust;
        c.command_valid  = valid;
        c.channel_scale  = 16'(scale);
        c.channel_number = 5'(ch);
        return c;
    endfunction

    function automatic tpcm_in_t random_cmd();
        int sel;
        int t;
        int s;
        sel = $urandom_range(99);
        if (sel < 35) begin
            t = int'($urandom_range(1048576)) - 524288;
        end else if (sel < 55) begin
            t = int'($urandom_range(65536)) - 32768;
        end else if (sel < 70) begin
            // around the dead band edges of both polynomials
            case ($urandom_range(3))
                0:       t = -23783;
                1:       t = 26752;
                2:       t = -19660;
                default: t = 19660;
            endcase
            t = t + int'($urandom_range(8)) - 4;
        end else if (sel < 80) begin
            case ($urandom_range(4))
                0:       t = THRUST_MAX;
                1:       t = THRUST_MIN;
                2:       t = THRUST_MAX - int'($urandom_range(100));
                3:       t = THRUST_MIN + int'($urandom_range(100));
                default: t = 0;
            endcase
        end else begin
            t = $urandom;
        end
        sel = $urandom_range(99);
        if (sel < 50) begin
            s = int'($urandom_range(UNITY)) + UNITY / 2;
        end else if (sel < 65) begin
            s = UNITY;
        end else if (sel < 85) begin
            s = $urandom;
        end else begin
            case ($urandom_range(3))
                0:       s = 32767;
                1:       s = -32768;
                2:       s = 0;
                default: s = -UNITY;
            endcase
        end
        return make_cmd(t, $urandom_range(9) != 0, s,
                        ($urandom_range(6) != 0) ? $urandom_range(1, NUM_CH)
                                                 : $urandom_range(31));
    endfunction

    task automatic send_cmd(input tpcm_in_t cmd);
        if (sent < SWAP_AT) begin
            send_idle  = 17;
            ready_idle = 81;
        end else if (sent < CALM_AT) begin
            send_idle  = 81;
            ready_idle = 17;
        end else begin
            send_idle  = 0;
            ready_idle = 0;
        end
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // hold off requests until every pulse width has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [1:0] model, input logic [15:0] gain);
        wait_idle();
        // junk in the unused upper bits
        apb_access(1'b1, ADDR_MODEL, ($urandom & 32'hFFFF_FFFC) | 32'(model));
        apb_access(1'b1, ADDR_GAIN, ($urandom & 32'hFFFF_0000) | 32'(gain));
        apb_access(1'b0, ADDR_MODEL, '0);
        apb_access(1'b0, ADDR_GAIN, '0);
    endtask

    initial begin : stimulus
        int          p;
        int          i;
        logic [1:0]  model;
        logic [15:0] gain;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: first polynomial, dead band edges, extremes, a missing command and bad channels
        send_cmd(make_cmd(0, 1'b1, UNITY, 1));
        send_cmd(make_cmd(-23784, 1'b1, UNITY, 2));
        send_cmd(make_cmd(-23783, 1'b1, UNITY, 3));
        send_cmd(make_cmd(26751, 1'b1, UNITY, 4));
        send_cmd(make_cmd(26752, 1'b1, UNITY, 5));
        send_cmd(make_cmd(THRUST_MAX, 1'b1, UNITY, NUM_CH));
        send_cmd(make_cmd(THRUST_MIN, 1'b1, UNITY, 6));
        send_cmd(make_cmd(2 * 65536, 1'b1, 32767, 7));
        send_cmd(make_cmd(-2 * 65536, 1'b1, -32768, 8));
        send_cmd(make_cmd(65536, 1'b0, UNITY, 9));
        send_cmd(make_cmd(65536, 1'b1, UNITY, 0));
        send_cmd(make_cmd(65536, 1'b1, UNITY, NUM_CH + 1));
        send_cmd(make_cmd(65536, 1'b1, UNITY, 31));
        send_cmd(make_cmd(65536, 1'b1, 0, 10));

        configure(MODEL_POLY_B, 16'd5120);
        send_cmd(make_cmd(-19661, 1'b1, UNITY, 1));
        send_cmd(make_cmd(-19660, 1'b1, UNITY, 2));
        send_cmd(make_cmd(19660, 1'b1, UNITY, 3));
        send_cmd(make_cmd(19661, 1'b1, UNITY, 4));
        send_cmd(make_cmd(THRUST_MAX, 1'b1, 32767, 5));
        send_cmd(make_cmd(THRUST_MIN, 1'b1, -32768, 6));

        configure(MODEL_LINEAR, 16'sh7FFF);
        send_cmd(make_cmd(THRUST_MAX, 1'b1, UNITY, 11));
        send_cmd(make_cmd(THRUST_MIN, 1'b1, UNITY, 12));
        send_cmd(make_cmd(65536, 1'b1, UNITY, 13));
        configure(MODEL_LINEAR, 16'sh8000);
        send_cmd(make_cmd(THRUST_MAX, 1'b1, UNITY, 14));

        for (p = 0; p < PHASES; p++) begin
            gain = $urandom;
            case (p % 5)
                0:       model = MODEL_POLY_A;
                1:       model = MODEL_POLY_B;
                3:       model = MODEL_SPARE;
                default: model = MODEL_LINEAR;
            endcase
            if (p == 2) begin
                gain = 16'sh7FFF;
            end else if (p == 4) begin
                gain = '0;
            end else if (p == 7) begin
                gain = 16'sh8000;
            end
            configure(model, gain);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2) begin
                    wait_idle();
                end
                send_cmd(random_cmd());
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
